// File: rtl/core/bfea_pkg.sv
// package: shared constants and types for the best-fit extent allocator
`default_nettype none
package bfea_pkg;
	localparam int ENTRIES   = 64;
	localparam int ADDR_BITS = 48;
	localparam int SIZE_BITS = 40;
	localparam int IDX_BITS  = $clog2(ENTRIES);

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_FIT  = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_L,
		S_SCAN_R,
		S_COMMIT,
		S_DONE
	} state_t;

	// one memory entry: base and length
	typedef struct packed {
		logic [ADDR_BITS-1:0] base;
		logic [SIZE_BITS-1:0] len;
	} entry_t;

	// write port command from sequencer to table
	typedef struct packed {
		logic                en;
		logic [IDX_BITS-1:0] idx;
		entry_t              data;
	} wr_cmd_t;
endpackage
`default_nettype wire

// File: rtl/core/bfea_table.sv
// module: extent memory, one write port and one registered read port
`default_nettype none
module bfea_table (
	input  wire logic                         clk,
	input  wire bfea_pkg::wr_cmd_t            wr,
	input  wire logic [bfea_pkg::IDX_BITS-1:0] rd_idx,
	output bfea_pkg::entry_t                  rd_data
);
	bfea_pkg::entry_t mem [bfea_pkg::ENTRIES];

	// synchronous write and read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
		rd_data <= mem[rd_idx];
	end
endmodule
`default_nettype wire

// File: rtl/core/best_fit_extent_allocator.sv
// module: top level of the best-fit extent allocator
// Usage: one request item enters on req_valid/req_stall with req_type,
// req_addr and req_size; one result item leaves on rsp_valid/rsp_stall with
// alloc_addr, status, bytes_in_use and peak_used.
// The free extents live in a 64-entry memory with a registered read port;
// valid bits are flip-flops. The memory read port sets the timing: one entry
// a cycle. An allocate walks every entry once; a free walks the table twice,
// once for the left neighbor and once for the right. A zero size skips the
// scans and goes straight to the done state with status invalid.
// One item is worked at a time. A stalled result holds in the output
// register until taken while the next item is accepted and scanned; that
// item's result waits in its last state, with req_stall high, until the
// output register frees.
// Reset empties the table (valid bits clear) and zeroes the byte counters;
// no clearing pass is needed.
`default_nettype none
module best_fit_extent_allocator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic        req_type,
	input  wire logic [47:0] req_addr,
	input  wire logic [39:0] req_size,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [47:0]      alloc_addr,
	output logic [1:0]       status,
	output logic [47:0]      bytes_in_use,
	output logic [47:0]      peak_used
);
	localparam int AB = bfea_pkg::ADDR_BITS;
	localparam int SB = bfea_pkg::SIZE_BITS;
	localparam int IB = bfea_pkg::IDX_BITS;
	localparam int N  = bfea_pkg::ENTRIES;
	localparam logic [AB-1:0] AMAX = '1;

	bfea_pkg::state_t state_q, state_d;
	logic [N-1:0]  valid_q;
	logic          type_q;
	logic [AB-1:0] addr_q, end_q;
	logic [SB-1:0] size_q;
	// scan pointer: issue index and delayed compare index
	logic [IB:0]   cnt_q;
	logic          cmp_v_q;
	logic [IB-1:0] cmp_idx_q;
	// best fit / neighbor tracking
	logic          best_v_q;
	logic [IB-1:0] best_idx_q;
	bfea_pkg::entry_t best_q;
	logic          left_v_q, right_v_q;
	logic [IB-1:0] left_idx_q, right_idx_q;
	logic [AB-1:0] mbase_q;
	logic [SB-1:0] mlen_q;
	logic [AB-1:0] used_q, peak_q;
	logic [31:0]   grant_q, release_q;
	// result of the item in work, then the output register
	logic [47:0]   res_addr_q;
	logic [1:0]    res_st_q;
	logic          out_v_q;
	logic [47:0]   out_addr_q;
	logic [1:0]    out_st_q;
	logic [AB-1:0] out_used_q, out_peak_q;

	bfea_pkg::wr_cmd_t wr;
	bfea_pkg::entry_t  rd_data;
	logic [IB-1:0]     rd_idx;

	bfea_table u_table (.clk(clk), .wr(wr), .rd_idx(rd_idx), .rd_data(rd_data));

	assign rd_idx = cnt_q[IB-1:0];
	assign req_stall = (state_q != bfea_pkg::S_IDLE);
	logic take;
	assign take = req_valid && !req_stall;
	logic out_free;
	assign out_free = !out_v_q || !rsp_stall;

	// lowest free slot after merged neighbors are released
	logic [N-1:0]  vmask;
	logic          slot_v;
	logic [IB-1:0] slot_idx;
	always_comb begin
		vmask = valid_q;
		if (left_v_q) vmask[left_idx_q] = 1'b0;
		if (right_v_q) vmask[right_idx_q] = 1'b0;
		slot_v = 1'b0;
		slot_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (!vmask[i]) begin
				slot_v = 1'b1;
				slot_idx = IB'(i);
			end
		end
	end

	// entry compare terms
	logic          ent_ok;
	logic [AB-1:0] ent_end;
	logic [SB:0]   room;
	assign ent_ok  = cmp_v_q && valid_q[cmp_idx_q];
	assign ent_end = rd_data.base + AB'(rd_data.len);
	assign room    = {1'b0, {SB{1'b1}}} - {1'b0, mlen_q};

	// next state and write command
	logic scan_last;
	assign scan_last = cmp_v_q && (cmp_idx_q == IB'(N - 1));
	always_comb begin
		state_d = state_q;
		wr = '0;
		case (state_q)
			bfea_pkg::S_IDLE: if (take) begin
				state_d = (req_size == '0) ? bfea_pkg::S_DONE : bfea_pkg::S_SCAN_L;
			end
			bfea_pkg::S_SCAN_L: if (scan_last) begin
				state_d = type_q ? bfea_pkg::S_SCAN_R : bfea_pkg::S_COMMIT;
			end
			bfea_pkg::S_SCAN_R: if (scan_last) state_d = bfea_pkg::S_COMMIT;
			bfea_pkg::S_COMMIT: begin
				if (!type_q) begin
					wr.en = best_v_q && (best_q.len != size_q);
					wr.idx = best_idx_q;
					wr.data.base = best_q.base + AB'(size_q);
					wr.data.len = best_q.len - size_q;
				end else begin
					wr.en = slot_v;
					wr.idx = slot_idx;
					wr.data.base = mbase_q;
					wr.data.len = mlen_q;
				end
				state_d = bfea_pkg::S_DONE;
			end
			bfea_pkg::S_DONE: if (out_free) state_d = bfea_pkg::S_IDLE;
			default: state_d = bfea_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= bfea_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// request capture (payload)
	always_ff @(posedge clk) begin
		if (take) begin
			type_q <= req_type;
			addr_q <= req_addr;
			size_q <= req_size;
			end_q  <= req_addr + AB'(req_size);
		end
	end

	// scan pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			cmp_v_q <= 1'b0;
			cmp_idx_q <= '0;
		end else if (take || (state_q == bfea_pkg::S_SCAN_L && scan_last)) begin
			cnt_q <= '0;
			cmp_v_q <= 1'b0;
		end else if ((state_q == bfea_pkg::S_SCAN_L || state_q == bfea_pkg::S_SCAN_R)
		             && cnt_q != (IB+1)'(N)) begin
			cmp_v_q <= 1'b1;
			cmp_idx_q <= cnt_q[IB-1:0];
			cnt_q <= cnt_q + 1'b1;
		end else begin
			cmp_v_q <= 1'b0;
		end
	end

	// search results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_v_q <= 1'b0;
			best_idx_q <= '0;
			best_q <= '0;
			left_v_q <= 1'b0;
			right_v_q <= 1'b0;
			left_idx_q <= '0;
			right_idx_q <= '0;
			mbase_q <= '0;
			mlen_q <= '0;
		end else if (take) begin
			best_v_q <= 1'b0;
			left_v_q <= 1'b0;
			right_v_q <= 1'b0;
			mbase_q <= req_addr;
			mlen_q <= req_size;
		end else if (state_q == bfea_pkg::S_SCAN_L && ent_ok) begin
			if (!type_q) begin
				if (rd_data.len >= size_q && (!best_v_q || rd_data.len < best_q.len ||
				    (rd_data.len == best_q.len && rd_data.base < best_q.base))) begin
					best_v_q <= 1'b1;
					best_idx_q <= cmp_idx_q;
					best_q <= rd_data;
				end
			end else if (!left_v_q && ent_end == addr_q && {1'b0, rd_data.len} <= room) begin
				left_v_q <= 1'b1;
				left_idx_q <= cmp_idx_q;
				mbase_q <= rd_data.base;
				mlen_q <= mlen_q + rd_data.len;
			end
		end else if (state_q == bfea_pkg::S_SCAN_R && ent_ok) begin
			if (!right_v_q && !(left_v_q && left_idx_q == cmp_idx_q) &&
			    rd_data.base == end_q && {1'b0, rd_data.len} <= room) begin
				right_v_q <= 1'b1;
				right_idx_q <= cmp_idx_q;
				mlen_q <= mlen_q + rd_data.len;
			end
		end
	end

	// commit: next valid bits, counters and result code
	logic [AB:0]   used_sum;
	logic [N-1:0]  valid_d;
	logic [AB-1:0] used_d, peak_d;
	logic [31:0]   grant_d, release_d;
	logic [47:0]   commit_addr;
	logic [1:0]    commit_st;
	assign used_sum = {1'b0, used_q} + (AB+1)'(size_q);
	always_comb begin
		valid_d = valid_q;
		used_d = used_q;
		peak_d = peak_q;
		grant_d = grant_q;
		release_d = release_q;
		commit_addr = '0;
		commit_st = bfea_pkg::ST_OK;
		if (state_q == bfea_pkg::S_COMMIT) begin
			if (!type_q) begin
				if (!best_v_q) begin
					commit_st = bfea_pkg::ST_NO_FIT;
				end else begin
					commit_addr = best_q.base;
					if (best_q.len == size_q) valid_d[best_idx_q] = 1'b0;
					grant_d = grant_q + 32'd1;
					if (used_sum[AB]) begin
						used_d = AMAX;
						peak_d = AMAX;
					end else begin
						used_d = used_sum[AB-1:0];
						if (used_sum[AB-1:0] > peak_q) peak_d = used_sum[AB-1:0];
					end
				end
			end else if (!left_v_q && !right_v_q && !slot_v) begin
				commit_st = bfea_pkg::ST_FULL;
			end else begin
				valid_d = vmask;
				if (slot_v) valid_d[slot_idx] = 1'b1;
				release_d = release_q + 32'd1;
				used_d = (used_q > AB'(size_q)) ? used_q - AB'(size_q) : '0;
			end
		end
	end

	// state registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q <= '0;
			peak_q <= '0;
			grant_q <= '0;
			release_q <= '0;
			res_addr_q <= '0;
			res_st_q <= bfea_pkg::ST_OK;
			out_v_q <= 1'b0;
			out_addr_q <= '0;
			out_st_q <= bfea_pkg::ST_OK;
			out_used_q <= '0;
			out_peak_q <= '0;
		end else begin
			valid_q <= valid_d;
			used_q <= used_d;
			peak_q <= peak_d;
			grant_q <= grant_d;
			release_q <= release_d;
			if (take && req_size == '0) begin
				res_addr_q <= '0;
				res_st_q <= bfea_pkg::ST_INVALID;
			end else if (state_q == bfea_pkg::S_COMMIT) begin
				res_addr_q <= commit_addr;
				res_st_q <= commit_st;
			end
			if (state_q == bfea_pkg::S_DONE && out_free) begin
				out_v_q <= 1'b1;
				out_addr_q <= res_addr_q;
				out_st_q <= res_st_q;
				out_used_q <= used_q;
				out_peak_q <= peak_q;
			end else if (out_v_q && !rsp_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign rsp_valid    = out_v_q;
	assign alloc_addr   = out_addr_q;
	assign status       = out_st_q;
	assign bytes_in_use = out_used_q;
	assign peak_used    = out_peak_q;

	// peak never below usage
	a_peak: assert property (@(posedge clk) disable iff (!arst_n) peak_q >= used_q)
		else $error("peak below usage");
	// a memory write happens only in commit
	a_wr: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> state_q == bfea_pkg::S_COMMIT) else $error("stray table write");
	// no item accepted while a scan runs
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfea_pkg::S_SCAN_L || state_q == bfea_pkg::S_SCAN_R) |-> req_stall)
		else $error("accept during scan");
	// a stalled result item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(alloc_addr) &&
		$stable(status) && $stable(bytes_in_use) && $stable(peak_used)))
		else $error("stalled result changed");
endmodule
`default_nettype wire

// File: dv/tb_top.sv
// testbench: best-fit extent allocator checked against a table predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;
	localparam logic [47:0] AMASK = 48'hFFFF_FFFF_FFFF;
	localparam logic [39:0] SMASK = 40'hFF_FFFF_FFFF;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic        req_type;
	logic [47:0] req_addr;
	logic [39:0] req_size;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [47:0] alloc_addr;
	logic [1:0]  status;
	logic [47:0] bytes_in_use;
	logic [47:0] peak_used;

	best_fit_extent_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.req_type(req_type), .req_addr(req_addr), .req_size(req_size),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.alloc_addr(alloc_addr), .status(status),
		.bytes_in_use(bytes_in_use), .peak_used(peak_used)
	);

	typedef struct packed {
		logic [47:0] addr;
		logic [1:0]  st;
		logic [47:0] used;
		logic [47:0] peak;
	} grant_t;

	// shadow free-extent table and byte counters
	logic        ext_valid [bfea_pkg::ENTRIES];
	logic [47:0] ext_base  [bfea_pkg::ENTRIES];
	logic [39:0] ext_len   [bfea_pkg::ENTRIES];
	logic [47:0] sh_used;
	logic [47:0] sh_peak;

	grant_t expected_grants[$];
	int     errors;
	int     sender_idle;
	int     receiver_stall;
	bit     hold_off;

	// directed table row: typed expectation used when chk is set
	typedef struct {
		logic        kind;
		logic [47:0] addr;
		logic [39:0] size;
		bit          chk;
		logic [1:0]  st;
		logic [47:0] gaddr;
	} vec_t;

	function automatic grant_t predict_grant(logic kind, logic [47:0] a, logic [39:0] sz);
		grant_t g;
		int best, lft, rgt, slot;
		logic [47:0] base, fin;
		logic [40:0] len;
		g = '0;
		best = -1; lft = -1; rgt = -1; slot = -1;
		if (sz == 0) begin
			g.st = bfea_pkg::ST_INVALID;
		end else if (kind == REQ_ALLOC) begin
			for (int i = 0; i < bfea_pkg::ENTRIES; i++) begin
				if (ext_valid[i] && ext_len[i] >= sz) begin
					if (best < 0 || ext_len[i] < ext_len[best] ||
					    (ext_len[i] == ext_len[best] && ext_base[i] < ext_base[best]))
						best = i;
				end
			end
			if (best < 0) begin
				g.st = bfea_pkg::ST_NO_FIT;
			end else begin
				g.addr = ext_base[best];
				g.st = bfea_pkg::ST_OK;
				if (ext_len[best] == sz) begin
					ext_valid[best] = 1'b0;
				end else begin
					ext_base[best] = ext_base[best] + 48'(sz);
					ext_len[best] = ext_len[best] - sz;
				end
				if ({1'b0, sz} > {1'b0, AMASK - sh_used}) sh_used = AMASK;
				else sh_used = sh_used + 48'(sz);
				if (sh_used > sh_peak) sh_peak = sh_used;
			end
		end else begin
			base = a;
			len = {1'b0, sz};
			fin = a + 48'(sz);
			// left neighbor ends at the address, lowest index wins
			for (int i = 0; i < bfea_pkg::ENTRIES; i++) begin
				if (lft < 0 && ext_valid[i] && (ext_base[i] + 48'(ext_len[i])) == a &&
				    {1'b0, ext_len[i]} <= {1'b0, SMASK} - len)
					lft = i;
			end
			if (lft >= 0) begin
				base = ext_base[lft];
				len = len + ext_len[lft];
			end
			// right neighbor starts at the end
			for (int i = 0; i < bfea_pkg::ENTRIES; i++) begin
				if (rgt < 0 && ext_valid[i] && i != lft && ext_base[i] == fin &&
				    {1'b0, ext_len[i]} <= {1'b0, SMASK} - len)
					rgt = i;
			end
			if (rgt >= 0) len = len + ext_len[rgt];
			if (lft >= 0) ext_valid[lft] = 1'b0;
			if (rgt >= 0) ext_valid[rgt] = 1'b0;
			for (int i = 0; i < bfea_pkg::ENTRIES; i++) begin
				if (slot < 0 && !ext_valid[i]) slot = i;
			end
			if (slot < 0) begin
				g.st = bfea_pkg::ST_FULL;
			end else begin
				ext_valid[slot] = 1'b1;
				ext_base[slot] = base;
				ext_len[slot] = len[39:0];
				g.st = bfea_pkg::ST_OK;
				if (sh_used > 48'(sz)) sh_used = sh_used - 48'(sz);
				else sh_used = '0;
			end
		end
		g.used = sh_used;
		g.peak = sh_peak;
		return g;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#200ms;
		$display("FAIL");
		$finish;
	end

	// receiver: random stall, plus a long hold-off when asked
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				rsp_stall <= 1'b1;
				repeat (1500) @(posedge clk);
				hold_off = 1'b0;
			end
			rsp_stall <= ($urandom_range(99) < receiver_stall);
		end
	end

	// result checker
	always @(posedge clk) begin
		grant_t g;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_grants.size() == 0) begin
				$display("%0t unexpected item: addr %h status %0d", $time, alloc_addr, status);
				errors++;
			end else begin
				g = expected_grants.pop_front();
				if (alloc_addr !== g.addr) begin
					$display("%0t alloc_addr exp %h got %h", $time, g.addr, alloc_addr);
					errors++;
				end
				if (status !== g.st) begin
					$display("%0t status exp %0d got %0d", $time, g.st, status);
					errors++;
				end
				if (bytes_in_use !== g.used) begin
					$display("%0t bytes_in_use exp %h got %h", $time, g.used, bytes_in_use);
					errors++;
				end
				if (peak_used !== g.peak) begin
					$display("%0t peak_used exp %h got %h", $time, g.peak, peak_used);
					errors++;
				end
			end
		end
	end

	task automatic send_request(logic kind, logic [47:0] a, logic [39:0] sz,
	                            bit chk, logic [1:0] st, logic [47:0] ga);
		grant_t g;
		while ($urandom_range(99) < sender_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= kind;
		req_addr <= a;
		req_size <= sz;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		g = predict_grant(kind, a, sz);
		if (chk && (g.st !== st || g.addr !== ga)) begin
			$display("%0t directed row exp status %0d addr %h, predicted %0d %h",
			         $time, st, ga, g.st, g.addr);
			errors++;
		end
		expected_grants.push_back(g);
	endtask

	// random size: mostly small, sometimes extreme
	function automatic logic [39:0] pick_size();
		case ($urandom_range(9))
			0: return 40'({$urandom, $urandom});
			1: return SMASK - 40'($urandom_range(3));
			default: return 40'($urandom_range(1, 64));
		endcase
	endfunction

	vec_t directed[$];
	logic [47:0] spots[$];

	initial begin
		logic [47:0] a;
		logic [39:0] sz;
		int pick;
		errors = 0;
		sender_idle = 0;
		receiver_stall = 0;
		hold_off = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_type = REQ_ALLOC;
		req_addr = '0;
		req_size = '0;
		for (int i = 0; i < bfea_pkg::ENTRIES; i++) begin
			ext_valid[i] = 1'b0;
			ext_base[i] = '0;
			ext_len[i] = '0;
		end
		sh_used = '0;
		sh_peak = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, invalid size, extremes, merges, wrap
		directed = '{
			'{REQ_ALLOC, 48'h0, 40'd16, 1, bfea_pkg::ST_NO_FIT, 48'h0},
			'{REQ_ALLOC, 48'h0, 40'd0, 1, bfea_pkg::ST_INVALID, 48'h0},
			'{REQ_FREE, 48'h1234, 40'd0, 1, bfea_pkg::ST_INVALID, 48'h0},
			'{REQ_FREE, 48'h1000, 40'h100, 1, bfea_pkg::ST_OK, 48'h0},
			'{REQ_FREE, 48'h1100, 40'h100, 1, bfea_pkg::ST_OK, 48'h0},
			'{REQ_FREE, 48'h0F00, 40'h100, 1, bfea_pkg::ST_OK, 48'h0},
			'{REQ_FREE, 48'h5000, 40'h80, 1, bfea_pkg::ST_OK, 48'h0},
			'{REQ_FREE, 48'h3000, 40'h80, 1, bfea_pkg::ST_OK, 48'h0},
			'{REQ_ALLOC, 48'h0, 40'h80, 1, bfea_pkg::ST_OK, 48'h3000},
			'{REQ_ALLOC, 48'h0, 40'h10, 1, bfea_pkg::ST_OK, 48'h5000},
			'{REQ_ALLOC, 48'h0, 40'h70, 1, bfea_pkg::ST_OK, 48'h5010},
			'{REQ_ALLOC, 48'h0, 40'h300, 1, bfea_pkg::ST_OK, 48'h0F00},
			'{REQ_FREE, AMASK - 48'hF, 40'h20, 0, bfea_pkg::ST_OK, 48'h0},
			'{REQ_FREE, 48'h10, 40'h8, 0, bfea_pkg::ST_OK, 48'h0},
			'{REQ_ALLOC, 48'h0, 40'h28, 1, bfea_pkg::ST_OK, AMASK - 48'hF},
			'{REQ_FREE, 48'h8000_0000_0000, SMASK, 0, bfea_pkg::ST_OK, 48'h0},
			'{REQ_FREE, 48'h8000_0000_0000 + 48'(SMASK), 40'h1, 0, bfea_pkg::ST_OK, 48'h0},
			'{REQ_FREE, 48'h7FFF_FFFF_FFF0, 40'h10, 0, bfea_pkg::ST_OK, 48'h0},
			'{REQ_ALLOC, 48'h0, SMASK, 1, bfea_pkg::ST_OK, 48'h8000_0000_0000},
			'{REQ_ALLOC, 48'h0, SMASK, 1, bfea_pkg::ST_NO_FIT, 48'h0},
			'{REQ_ALLOC, 48'h0, 40'h1, 0, bfea_pkg::ST_OK, 48'h0},
			'{REQ_FREE, AMASK, 40'h5555_5555_55, 0, bfea_pkg::ST_OK, 48'h0},
			'{REQ_FREE, 48'hAAAA_AAAA_AAAA, 40'hAA_AAAA_AAAA, 0, bfea_pkg::ST_OK, 48'h0}
		};
		foreach (directed[i])
			send_request(directed[i].kind, directed[i].addr, directed[i].size,
			             directed[i].chk, directed[i].st, directed[i].gaddr);

		// random phases: frees at scattered spots fill the table, allocs carve
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin sender_idle = 0;  receiver_stall = 0;  end
				1: begin sender_idle = 78; receiver_stall = 0;  end
				2: begin sender_idle = 0;  receiver_stall = 78; end
				3: begin sender_idle = 31; receiver_stall = 31; hold_off = 1'b1; end
				default: begin sender_idle = 0; receiver_stall = 0; hold_off = 1'b1; end
			endcase
			for (int n = 0; n < 100; n++) begin
				pick = $urandom_range(9);
				if (pick < 4) begin
					send_request(REQ_ALLOC, 48'({$urandom, $urandom}), pick_size(),
					             0, bfea_pkg::ST_OK, 48'h0);
				end else if (pick < 8 || spots.size() == 0) begin
					// adjacent frees so neighbors merge
					if (spots.size() > 0 && $urandom_range(1)) a = spots[$urandom_range(spots.size() - 1)];
					else a = 48'({$urandom, $urandom});
					if ($urandom_range(3) == 0) a = {8'($urandom_range(255)), 40'h0};
					sz = pick_size();
					send_request(REQ_FREE, a, sz, 0, bfea_pkg::ST_OK, 48'h0);
					spots.push_back(a + 48'(sz));
					if (spots.size() > 40) void'(spots.pop_front());
				end else if (pick == 8) begin
					send_request(1'($urandom_range(1)), 48'({$urandom, $urandom}), 40'd0,
					             0, bfea_pkg::ST_OK, 48'h0);
				end else begin
					// fresh random spots for filling the table
					send_request(REQ_FREE, {16'($urandom_range(65535)), 32'h0} + 48'd7, 40'd3,
					             0, bfea_pkg::ST_OK, 48'h0);
				end
			end
		end
		req_valid <= 1'b0;

		// drain
		for (int w = 0; w < 400000 && expected_grants.size() != 0; w++) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_grants.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
